// File: src/wpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint path interpolator package
// Shared types, widths and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package wpi_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int FRAC_EXTRA  = 16;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int PC_W        = $clog2(MAX_POINTS + 1);
   localparam int COORD_W     = 32;
   localparam int ACC_W       = COORD_W + FRAC_EXTRA;
   localparam int MU_W        = 20;
   localparam int STEPS_W     = 32;
   localparam int SUM_W       = 2 * COORD_W + 2;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int SQRT_ITERS  = ROOT_W;
   localparam int DIV_ITERS   = ACC_W;
   localparam int CNT_W       = $clog2(DIV_ITERS);
   localparam int ENTRY_W     = 2 * COORD_W + 1;

   localparam logic [MU_W-1:0] MOVE_UNIT_RESET   = MU_W'(1678);
   localparam logic [PC_W-1:0] POINT_COUNT_RESET = PC_W'(2);

   typedef enum logic [1:0] {
      CSR_MOVE_UNIT   = 2'd0,
      CSR_POINT_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      RD_START,
      RD_END,
      RD_LAST
   } rd_sel_type;

   typedef enum logic [1:0] {
      DIV_N,
      DIV_LAT,
      DIV_LNG
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_RD_END,
      ST_GOT_END,
      ST_SQ_LAT,
      ST_SQ_LNG,
      ST_SQRT_INIT,
      ST_SQRT_RUN,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_SEG_LOAD,
      ST_LAST_LOAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        mem_wr;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        latch_start;
      logic        latch_end;
      logic        sq_lat;
      logic        sq_lng;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        div_init;
      logic        div_step;
      logic        div_store;
      div_sel_type div_sel;
      logic        seg_load;
      logic        last_load;
      logic        step_adv;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic at_end;
      logic out_free;
   } status_type;

endpackage

// File: src/wpi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint path interpolator controller
// Sequences table access, squaring, square root and the shared divider.
// ----------------------------------------------------------------------------
module wpi_ctrl import wpi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   div_sel_type        div_sel_ff, div_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         div_sel_ff <= DIV_N;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         div_sel_ff <= div_sel_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      div_sel_in  = div_sel_ff;
      cmd         = '0;
      cmd.rd_sel  = RD_START;
      cmd.div_sel = div_sel_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind) state_in = ST_TICK;
               else cmd.mem_wr = 1'b1;
            end
         end
         ST_TICK: begin
            if (!status.steps_zero) begin
               cmd.step_adv = 1'b1;
               state_in     = ST_OUT;
            end else if (status.at_end) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_LAST_LOAD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_START;
               state_in   = ST_RD_END;
            end
         end
         ST_RD_END: begin
            cmd.latch_start = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_sel      = RD_END;
            state_in        = ST_GOT_END;
         end
         ST_GOT_END: begin
            cmd.latch_end = 1'b1;
            state_in      = ST_SQ_LAT;
         end
         ST_SQ_LAT: begin
            cmd.sq_lat = 1'b1;
            state_in   = ST_SQ_LNG;
         end
         ST_SQ_LNG: begin
            cmd.sq_lng = 1'b1;
            state_in   = ST_SQRT_INIT;
         end
         ST_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SQRT_RUN;
         end
         ST_SQRT_RUN: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_ITERS - 1)) begin
               div_sel_in = DIV_N;
               state_in   = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_ITERS - 1)) state_in = ST_DIV_STORE;
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            unique case (div_sel_ff)
               DIV_N: begin
                  div_sel_in = DIV_LAT;
                  state_in   = ST_DIV_INIT;
               end
               DIV_LAT: begin
                  div_sel_in = DIV_LNG;
                  state_in   = ST_DIV_INIT;
               end
               default: state_in = ST_SEG_LOAD;
            endcase
         end
         ST_SEG_LOAD: begin
            cmd.seg_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_LAST_LOAD: begin
            cmd.last_load = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/wpi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint path interpolator datapath
// Waypoint table, squarer, bit-pair square root, shared divider, accumulators.
// ----------------------------------------------------------------------------
module wpi_dp import wpi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [MU_W-1:0]    cfg_move_unit,
   input  logic [PC_W-1:0]    cfg_point_count,
   input  logic [IDX_W-1:0]   wr_index,
   input  logic [COORD_W-1:0] wr_lat,
   input  logic [COORD_W-1:0] wr_lng,
   input  logic               wr_mode,
   input  logic               out_ready,
   output logic               out_valid,
   output logic [COORD_W-1:0] out_lat,
   output logic [COORD_W-1:0] out_lng,
   output logic               out_mode,
   output logic               out_marker,
   output logic               out_finished
);

   logic [ENTRY_W-1:0] mem [MAX_POINTS];
   logic [ENTRY_W-1:0] rd_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic [IDX_W-1:0]   seg_ff;
   logic [COORD_W-1:0] start_lat_ff, start_lng_ff;
   logic               start_mode_ff, end_mode_ff;
   logic [COORD_W-1:0] mag_lat_ff, mag_lng_ff;
   logic               neg_lat_ff, neg_lng_ff;
   logic [2*COORD_W-1:0] prod_ff, sum_ff;
   logic [SUM_W-1:0]   rad_ff;
   logic [ROOT_W+2:0]  srem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [STEPS_W-1:0] drem_ff, divisor_ff;
   logic [ACC_W-1:0]   dq_ff;
   logic [STEPS_W-1:0] steps_ff;
   logic [ACC_W-1:0]   inc_lat_ff, inc_lng_ff, acc_lat_ff, acc_lng_ff;
   logic               held_mode_ff, mark_ff, fin_ff;
   logic               out_valid_ff;
   logic [COORD_W-1:0] out_lat_ff, out_lng_ff;
   logic               out_mode_ff, out_marker_ff, out_finished_ff;

   logic [PC_W-1:0]    pc_eff;
   logic [MU_W-1:0]    mu_eff;
   logic [COORD_W:0]   d_lat, d_lng;
   logic [COORD_W-1:0] mul_a;
   logic [ROOT_W+2:0]  sq_rem, sq_trial;
   logic               sq_ge;
   logic [STEPS_W:0]   dv_rem;
   logic               dv_ge;
   logic [ACC_W-1:0]   quot;

   always_comb begin
      if (cfg_point_count < PC_W'(2)) pc_eff = PC_W'(2);
      else if (cfg_point_count > PC_W'(MAX_POINTS)) pc_eff = PC_W'(MAX_POINTS);
      else pc_eff = cfg_point_count;
      mu_eff = (cfg_move_unit == '0) ? MU_W'(1) : cfg_move_unit;
   end

   assign status.steps_zero = (steps_ff == '0);
   assign status.at_end     = ({1'b0, seg_ff} + PC_W'(1)) >= pc_eff;
   assign status.out_free   = !out_valid_ff || out_ready;

   // Table memory: one write port, one registered read port.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_START: rd_addr = seg_ff;
         RD_END:   rd_addr = seg_ff + 1'b1;
         default:  rd_addr = IDX_W'(pc_eff - 1'b1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) mem[wr_index] <= {wr_mode, wr_lng, wr_lat};
      if (cmd.rd_en)  rd_ff <= mem[rd_addr];
   end

   // Segment deltas from the end point in rd_ff and the latched start point.
   assign d_lat = {rd_ff[COORD_W-1], rd_ff[COORD_W-1:0]}
                - {start_lat_ff[COORD_W-1], start_lat_ff};
   assign d_lng = {rd_ff[2*COORD_W-1], rd_ff[2*COORD_W-1:COORD_W]}
                - {start_lng_ff[COORD_W-1], start_lng_ff};
   assign mul_a = cmd.sq_lng ? mag_lng_ff : mag_lat_ff;

   // Square root: one bit pair per cycle.
   assign sq_rem   = {srem_ff[ROOT_W:0], rad_ff[SUM_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_rem >= sq_trial;

   // Restoring divider: one quotient bit per cycle.
   assign dv_rem = {drem_ff, dq_ff[ACC_W-1]};
   assign dv_ge  = dv_rem >= {1'b0, divisor_ff};
   assign quot   = dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_start) begin
         start_lat_ff  <= rd_ff[COORD_W-1:0];
         start_lng_ff  <= rd_ff[2*COORD_W-1:COORD_W];
         start_mode_ff <= rd_ff[ENTRY_W-1];
      end
      if (cmd.latch_end) begin
         neg_lat_ff  <= d_lat[COORD_W];
         neg_lng_ff  <= d_lng[COORD_W];
         mag_lat_ff  <= d_lat[COORD_W] ? COORD_W'(-d_lat) : d_lat[COORD_W-1:0];
         mag_lng_ff  <= d_lng[COORD_W] ? COORD_W'(-d_lng) : d_lng[COORD_W-1:0];
         end_mode_ff <= rd_ff[ENTRY_W-1];
      end
      if (cmd.sq_lat || cmd.sq_lng) prod_ff <= mul_a * mul_a;
      if (cmd.sq_lng) sum_ff <= prod_ff;
      if (cmd.sqrt_init) begin
         rad_ff  <= {2'b00, sum_ff} + {2'b00, prod_ff};
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[SUM_W-3:0], 2'b00};
         srem_ff <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
         root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
      end
      if (cmd.div_init) begin
         drem_ff <= '0;
         unique case (cmd.div_sel)
            DIV_N: begin
               dq_ff      <= ACC_W'(root_ff);
               divisor_ff <= STEPS_W'(mu_eff);
            end
            DIV_LAT: begin
               dq_ff      <= {mag_lat_ff, FRAC_EXTRA'(0)};
               divisor_ff <= steps_ff;
            end
            default: begin
               dq_ff      <= {mag_lng_ff, FRAC_EXTRA'(0)};
               divisor_ff <= steps_ff;
            end
         endcase
      end else if (cmd.div_step) begin
         drem_ff <= dv_ge ? STEPS_W'(dv_rem - {1'b0, divisor_ff})
                          : dv_rem[STEPS_W-1:0];
         dq_ff   <= {dq_ff[ACC_W-2:0], dv_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= '0;
         steps_ff     <= '0;
         acc_lat_ff   <= '0;
         acc_lng_ff   <= '0;
         inc_lat_ff   <= '0;
         inc_lng_ff   <= '0;
         held_mode_ff <= 1'b0;
         mark_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.div_store) begin
            unique case (cmd.div_sel)
               DIV_N: steps_ff <= (quot[ACC_W-1:STEPS_W] != '0) ? '1
                                  : quot[STEPS_W-1:0];
               DIV_LAT: inc_lat_ff <= (steps_ff == '0) ? '0
                                      : (neg_lat_ff ? (ACC_W'(0) - quot) : quot);
               default: inc_lng_ff <= (steps_ff == '0) ? '0
                                      : (neg_lng_ff ? (ACC_W'(0) - quot) : quot);
            endcase
         end
         if (cmd.seg_load) begin
            seg_ff       <= seg_ff + 1'b1;
            acc_lat_ff   <= {start_lat_ff, FRAC_EXTRA'(0)};
            acc_lng_ff   <= {start_lng_ff, FRAC_EXTRA'(0)};
            held_mode_ff <= start_mode_ff;
            mark_ff      <= end_mode_ff;
            fin_ff       <= 1'b0;
         end
         if (cmd.last_load) begin
            acc_lat_ff   <= {rd_ff[COORD_W-1:0], FRAC_EXTRA'(0)};
            acc_lng_ff   <= {rd_ff[2*COORD_W-1:COORD_W], FRAC_EXTRA'(0)};
            held_mode_ff <= rd_ff[ENTRY_W-1];
            inc_lat_ff   <= '0;
            inc_lng_ff   <= '0;
            steps_ff     <= '0;
            mark_ff      <= 1'b0;
            fin_ff       <= 1'b1;
         end
         if (cmd.step_adv) begin
            steps_ff   <= steps_ff - 1'b1;
            acc_lat_ff <= acc_lat_ff + inc_lat_ff;
            acc_lng_ff <= acc_lng_ff + inc_lng_ff;
            mark_ff    <= 1'b0;
            fin_ff     <= 1'b0;
         end
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_lat_ff      <= acc_lat_ff[ACC_W-1:FRAC_EXTRA];
         out_lng_ff      <= acc_lng_ff[ACC_W-1:FRAC_EXTRA];
         out_mode_ff     <= held_mode_ff;
         out_marker_ff   <= mark_ff;
         out_finished_ff <= fin_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_lat      = out_lat_ff;
   assign out_lng      = out_lng_ff;
   assign out_mode     = out_mode_ff;
   assign out_marker   = out_marker_ff;
   assign out_finished = out_finished_ff;

endmodule

// File: src/waypoint_path_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint path interpolator unit
// Moves a position along a polyline of up to 64 waypoints, one step per tick.
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one waypoint into the table and is taken
// while the controller is idle. A tick request (tuser 1) returns one response
// with the current position. A tick that enters a new segment runs two table
// reads, two squarings on one shared 32 by 32 multiplier, a bit-pair square
// root and three passes of one shared restoring divider (step count, latitude
// increment, longitude increment), which dominates the work. A tick at the
// end of the path reports finished. The response sits in an output register,
// so a new request is accepted while it waits to be taken. Table entries are
// undefined until written; the configuration port is always ready and should
// be written only while idle.
module waypoint_path_interpolator_unit import wpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // point_index[5:0], point_lat, point_lng, point_mode
   input  logic        req_tuser,  // kind
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // cur_lat[31:0], cur_lng, cur_mode, zero fill
   output logic [1:0]  rsp_tuser,  // marker, finished
   // Configuration channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   cmd_type          cmd;
   status_type       status;
   logic [MU_W-1:0]  move_unit_ff;
   logic [PC_W-1:0]  point_count_ff;
   logic [COORD_W-1:0] out_lat, out_lng;
   logic             out_mode, out_marker, out_finished;

   // Configuration registers: always ready; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_unit_ff   <= MOVE_UNIT_RESET;
         point_count_ff <= POINT_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MOVE_UNIT:   move_unit_ff   <= csr_data[MU_W-1:0];
            CSR_POINT_COUNT: point_count_ff <= csr_data[PC_W-1:0];
            default: ;
         endcase
      end
   end

   wpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   wpi_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg_move_unit   (move_unit_ff),
      .cfg_point_count (point_count_ff),
      .wr_index        (req_tdata[IDX_W-1:0]),
      .wr_lat          (req_tdata[37:6]),
      .wr_lng          (req_tdata[69:38]),
      .wr_mode         (req_tdata[70]),
      .out_ready       (rsp_tready),
      .out_valid       (rsp_tvalid),
      .out_lat         (out_lat),
      .out_lng         (out_lng),
      .out_mode        (out_mode),
      .out_marker      (out_marker),
      .out_finished    (out_finished)
   );

   assign rsp_tdata = {7'b0, out_mode, out_lng, out_lat};
   assign rsp_tuser = {out_finished, out_marker};

   // A response can only appear after the request side has been held off.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised while requests were being accepted");

   // The end of the path never raises a marker.
   a_fin_no_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("finished response carries a marker");

endmodule
